// ===== rtl/dsel_pkg.sv =====
package dsel_pkg;

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned HEIGHT_W   = 16;
  localparam int unsigned COORD_W    = 9;
  localparam int unsigned COLS_W     = 10;
  localparam int unsigned STEP_W     = 7;
  localparam int unsigned DIST_W     = HEIGHT_W + 3;

  localparam logic [CFG_ADDR_W-1:0] REG_COLS_IN_USE    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ROWS_IN_USE    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_EDGE_STEP      = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_STEP_THRESHOLD = 2'd3;

  localparam logic [COLS_W-1:0]   COLS_RESET = 10'd512;
  localparam logic [COLS_W-1:0]   ROWS_RESET = 10'd512;
  localparam logic [STEP_W-1:0]   STEP_RESET = 7'd1;
  localparam logic [HEIGHT_W-1:0] THR_RESET  = 16'd100;

  localparam int unsigned NUM_PAIRS = 8;
  localparam int unsigned PAIR_W    = 3;
  localparam int unsigned IDX_W     = 5;
  localparam logic [IDX_W-1:0] LAST_IDX = 5'd16;

  typedef enum logic [1:0] {
    DIR_NEG,
    DIR_ZERO,
    DIR_POS
  } dir_t;

  typedef struct packed {
    logic             latch;
    logic             decode;
    logic             write;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             proc_en;
    logic [IDX_W-1:0] proc_idx;
  } dsel_cmd_t;

  typedef struct packed {
    logic is_query;
    logic in_range;
  } dsel_stat_t;

  function automatic dir_t pair_dir_row(input logic [PAIR_W-1:0] p);
    dir_t d;
    case (p)
      3'd0, 3'd1, 3'd2: d = DIR_NEG;
      3'd3, 3'd4:       d = DIR_ZERO;
      default:          d = DIR_POS;
    endcase
    return d;
  endfunction

  function automatic dir_t pair_dir_col(input logic [PAIR_W-1:0] p);
    dir_t d;
    case (p)
      3'd0, 3'd3, 3'd5: d = DIR_NEG;
      3'd1, 3'd6:       d = DIR_ZERO;
      default:          d = DIR_POS;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/dsel_ram.sv =====
module dsel_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 262144,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/dsel_ctrl.sv =====
module dsel_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output logic               out_valid,
  input  dsel_pkg::dsel_stat_t stat,
  output dsel_pkg::dsel_cmd_t  cmd
);
  import dsel_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_DRAIN,
    ST_DONE
  } state_t;

  state_t           state_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic             proc_en_r;
  logic [IDX_W-1:0] proc_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      rd_idx_r   <= '0;
      proc_en_r  <= 1'b0;
      proc_idx_r <= '0;
    end else begin
      proc_en_r  <= (state_r == ST_READ);
      proc_idx_r <= rd_idx_r;
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_r <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          rd_idx_r <= '0;
          if (!stat.is_query) begin
            state_r <= ST_IDLE;
          end else if (!stat.in_range) begin
            state_r <= ST_DONE;
          end else begin
            state_r <= ST_READ;
          end
        end
        ST_READ: begin
          rd_idx_r <= rd_idx_r + 1'b1;
          if (rd_idx_r == LAST_IDX) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: state_r <= ST_DONE;
        ST_DONE:  state_r <= ST_IDLE;
        default:  state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);

  always_comb begin
    cmd          = '0;
    cmd.latch    = start && (state_r == ST_IDLE);
    cmd.decode   = (state_r == ST_DECODE);
    cmd.write    = (state_r == ST_DECODE) && !stat.is_query;
    cmd.rd_en    = (state_r == ST_READ);
    cmd.rd_idx   = rd_idx_r;
    cmd.proc_en  = proc_en_r;
    cmd.proc_idx = proc_idx_r;
  end

endmodule

// ===== rtl/dsel_datapath.sv =====
module dsel_datapath #(
  parameter int unsigned MAX_COLS = 512,
  parameter int unsigned MAX_ROWS = 512
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [dsel_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [dsel_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_kind,
  input  logic [dsel_pkg::COORD_W-1:0]    in_row,
  input  logic [dsel_pkg::COORD_W-1:0]    in_col,
  input  logic [dsel_pkg::HEIGHT_W-1:0]   in_height,
  input  dsel_pkg::dsel_cmd_t             cmd,
  output dsel_pkg::dsel_stat_t            stat,
  output logic                            out_is_boundary,
  output logic                            out_status
);
  import dsel_pkg::*;

  localparam int unsigned DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned DIM_W0 = ($clog2(MAX_ROWS + 1) > $clog2(MAX_COLS + 1)) ?
                                   $clog2(MAX_ROWS + 1) : $clog2(MAX_COLS + 1);
  localparam int unsigned DIM_W  = (DIM_W0 > COLS_W) ? DIM_W0 : COLS_W;
  localparam int unsigned SW     = DIM_W + 2;

  logic [COLS_W-1:0]   cols_r;
  logic [COLS_W-1:0]   rows_r;
  logic [STEP_W-1:0]   step_r;
  logic [HEIGHT_W-1:0] thr_r;

  logic                kind_r;
  logic [COORD_W-1:0]  row_r;
  logic [COORD_W-1:0]  col_r;
  logic [HEIGHT_W-1:0] height_r;

  logic [HEIGHT_W-1:0] centre_r;
  logic [HEIGHT_W-1:0] nb_r;
  logic                hit_r;
  logic                err_r;

  logic [DIM_W-1:0]    rows_lim;
  logic [DIM_W-1:0]    cols_lim;
  logic                load_ok;
  logic [HEIGHT_W-1:0] rdata;

  logic [IDX_W-1:0]    rel_idx;
  logic [PAIR_W-1:0]   pair;
  logic                is_sec;
  logic [STEP_W:0]     offset;
  logic [DIM_W-1:0]    r_sel;
  logic [DIM_W-1:0]    c_sel;
  logic [AW-1:0]       ram_addr;
  logic signed [DIST_W-1:0] step_sum;

  function automatic logic [DIM_W-1:0] dim_clamp(input logic [COLS_W-1:0] v,
                                                 input int unsigned maxv);
    logic [DIM_W-1:0] res;
    if (32'(v) > maxv) begin
      res = DIM_W'(maxv);
    end else if (v == '0) begin
      res = DIM_W'(1);
    end else begin
      res = DIM_W'(v);
    end
    return res;
  endfunction

  function automatic logic [DIM_W-1:0] coord_step(input logic [COORD_W-1:0] base,
                                                  input dir_t d,
                                                  input logic [STEP_W:0] off,
                                                  input logic [DIM_W-1:0] lim);
    logic signed [SW-1:0] b;
    logic signed [SW-1:0] o;
    logic signed [SW-1:0] v;
    logic signed [SW-1:0] top;
    logic [DIM_W-1:0]     res;
    b   = $signed(SW'(base));
    o   = $signed(SW'(off));
    top = $signed(SW'(lim)) - $signed(SW'(1));
    case (d)
      DIR_NEG:  v = b - o;
      DIR_POS:  v = b + o;
      default:  v = b;
    endcase
    if (v < 0) begin
      res = '0;
    end else if (v > top) begin
      res = DIM_W'(top);
    end else begin
      res = DIM_W'(v);
    end
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= COLS_RESET;
      rows_r <= ROWS_RESET;
      step_r <= STEP_RESET;
      thr_r  <= THR_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_COLS_IN_USE:    cols_r <= cfg_wdata[COLS_W-1:0];
        REG_ROWS_IN_USE:    rows_r <= cfg_wdata[COLS_W-1:0];
        REG_EDGE_STEP:      step_r <= cfg_wdata[STEP_W-1:0];
        REG_STEP_THRESHOLD: thr_r  <= cfg_wdata[HEIGHT_W-1:0];
        default:            thr_r  <= thr_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r   <= in_kind;
      row_r    <= in_row;
      col_r    <= in_col;
      height_r <= in_height;
    end
  end

  assign rows_lim = dim_clamp(rows_r, MAX_ROWS);
  assign cols_lim = dim_clamp(cols_r, MAX_COLS);
  assign load_ok  = (32'(row_r) < MAX_ROWS) && (32'(col_r) < MAX_COLS);

  assign stat.is_query = kind_r;
  assign stat.in_range = (DIM_W'(row_r) < rows_lim) && (DIM_W'(col_r) < cols_lim);

  assign rel_idx = cmd.rd_idx - 1'b1;
  assign pair    = rel_idx[PAIR_W:1];
  assign is_sec  = rel_idx[0];
  assign offset  = is_sec ? {step_r, 1'b0} : {1'b0, step_r};

  always_comb begin
    if (cmd.rd_en && (cmd.rd_idx != '0)) begin
      r_sel = coord_step(row_r, pair_dir_row(pair), offset, rows_lim);
      c_sel = coord_step(col_r, pair_dir_col(pair), offset, cols_lim);
    end else begin
      r_sel = DIM_W'(row_r);
      c_sel = DIM_W'(col_r);
    end
  end

  assign ram_addr = AW'(32'(r_sel) * MAX_COLS + 32'(c_sel));

  dsel_ram #(
    .WIDTH (HEIGHT_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.write && load_ok),
    .re    (cmd.rd_en),
    .addr  (ram_addr),
    .wdata (height_r),
    .rdata (rdata)
  );

  assign step_sum = $signed(DIST_W'(centre_r)) - $signed(DIST_W'({nb_r, 1'b0}))
                  + $signed(DIST_W'(rdata));

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      hit_r <= 1'b0;
      err_r <= !stat.in_range;
    end else if (cmd.proc_en) begin
      if (cmd.proc_idx == '0) begin
        centre_r <= rdata;
      end else if (cmd.proc_idx[0]) begin
        nb_r <= rdata;
      end else if ((nb_r != '0) && (step_sum > $signed(DIST_W'(thr_r)))) begin
        hit_r <= 1'b1;
      end
    end
  end

  assign out_is_boundary = hit_r;
  assign out_status      = err_r;

endmodule

// ===== rtl/dsm_step_edge_labeler.sv =====
// channel  | handshake           | payload
// ---------+---------------------+------------------------------------------
// input    | start, busy         | in_kind, in_row, in_col, in_height
// result   | out_valid (strobe)  | out_is_boundary, out_status
// config   | cfg_we              | cfg_addr, cfg_wdata
//
// A load holds busy only through decode, with the RAM write at its closing edge.
// An in-range query holds busy through decode, 17 reads of the single-port height
// RAM (centre plus eight neighbour/second pairs), a drain state, and the result strobe.
// An out-of-range query strobes its error result straight after decode, with no RAM reads.
// Reset is synchronous, active low; it restores FSM and config registers, not the height RAM.
// The one-cycle result strobe cannot be stalled; busy drops between transactions.
module dsm_step_edge_labeler #(
  parameter int unsigned MAX_COLS = 512,
  parameter int unsigned MAX_ROWS = 512
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [dsel_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [dsel_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_kind,
  input  logic [dsel_pkg::COORD_W-1:0]    in_row,
  input  logic [dsel_pkg::COORD_W-1:0]    in_col,
  input  logic [dsel_pkg::HEIGHT_W-1:0]   in_height,
  output logic                            out_valid,
  output logic                            out_is_boundary,
  output logic                            out_status
);
  import dsel_pkg::*;

  dsel_cmd_t  cmd;
  dsel_stat_t stat;

  dsel_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  dsel_datapath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .in_kind         (in_kind),
    .in_row          (in_row),
    .in_col          (in_col),
    .in_height       (in_height),
    .cmd             (cmd),
    .stat            (stat),
    .out_is_boundary (out_is_boundary),
    .out_status      (out_status)
  );

endmodule

// ===== rtl/dsel_checker.sv =====
module dsel_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_is_boundary,
  input logic out_status
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted transaction");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  a_strobe_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe outside a busy transaction");

  a_release_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("busy held after the result");

  a_error_no_boundary: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> !out_is_boundary)
    else $error("boundary flagged on an error result");

endmodule

bind dsm_step_edge_labeler dsel_checker u_dsel_checker (.*);
